FILE: rtl/slte_pkg.sv
package slte_pkg;

	// default table depth
	localparam int unsigned DEPTH_DEF = 16;

	// request codes
	localparam logic [1:0] FN_INSERT  = 2'd0;
	localparam logic [1:0] FN_DEL_POS = 2'd1;
	localparam logic [1:0] FN_SEARCH  = 2'd2;
	localparam logic [1:0] FN_DEL_KEY = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_BADPOS = 3'd1;
	localparam logic [2:0] ST_NOKEY  = 3'd2;
	localparam logic [2:0] ST_EMPTY  = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	// one result item, as handed from the sequencer to the output register
	typedef struct packed {
		logic [2:0] status;
		logic [3:0] found_position;
		logic [4:0] count;
	} res_t;

endpackage

FILE: rtl/slte_mem.sv
module slte_mem #(
	parameter int unsigned DEPTH = slte_pkg::DEPTH_DEF,
	parameter int unsigned IW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [IW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// one write port, one read port, registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/slte_ctrl.sv
module slte_ctrl #(
	parameter int unsigned DEPTH = slte_pkg::DEPTH_DEF,
	parameter int unsigned IW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          func,
	input  logic [31:0]         value,
	input  logic [3:0]          position,
	output logic                idle,
	output logic                res_valid,
	input  logic                res_ack,
	output slte_pkg::res_t      res,
	output logic                mem_we,
	output logic [IW-1:0]       mem_waddr,
	output logic [31:0]         mem_wdata,
	output logic [IW-1:0]       mem_raddr,
	input  logic [31:0]         mem_rdata
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = CW + 4;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_RD  = 4'd1;
	localparam logic [3:0] S_INS_CMP = 4'd2;
	localparam logic [3:0] S_INS_PUT = 4'd3;
	localparam logic [3:0] S_SH_RD   = 4'd4;
	localparam logic [3:0] S_SH_WR   = 4'd5;
	localparam logic [3:0] S_KEY_RD  = 4'd6;
	localparam logic [3:0] S_KEY_CMP = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   val_q;
	logic          search_q;
	logic [2:0]    status_q;
	logic [3:0]    fpos_q;

	logic [EW-1:0] idx_ext;
	logic [EW-1:0] count_ext;
	logic [EW-1:0] pos_ext;
	logic          next_in_range;
	logic          rd_gt;
	logic          rd_eq;

	assign idx_ext       = {{(EW - IW){1'b0}}, idx_q};
	assign count_ext     = {4'b0, count_q};
	assign pos_ext       = {{CW{1'b0}}, position};
	assign next_in_range = (idx_ext + EW'(1)) < count_ext;
	assign rd_gt         = $signed(mem_rdata) > $signed(val_q);
	assign rd_eq         = mem_rdata == val_q;

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = '{status: status_q, found_position: fpos_q, count: count_ext[4:0]};

	// memory port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = val_q;
		mem_raddr = idx_q;
		unique case (state_q)
			S_INS_RD: begin
				mem_raddr = idx_q - IW'(1);
			end
			S_INS_CMP: begin
				// larger entry moves up one slot, else the new value lands here
				mem_we    = 1'b1;
				mem_wdata = rd_gt ? mem_rdata : val_q;
			end
			S_INS_PUT: begin
				mem_we = 1'b1;
			end
			S_SH_RD: begin
				mem_raddr = idx_q + IW'(1);
			end
			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q    <= value;
						search_q <= func == slte_pkg::FN_SEARCH;
						fpos_q   <= '0;
						status_q <= slte_pkg::ST_OK;
						unique case (func)
							slte_pkg::FN_INSERT: begin
								if (count_q == CW'(DEPTH)) begin
									status_q <= slte_pkg::ST_FULL;
									state_q  <= S_DONE;
								end else begin
									idx_q   <= count_q[IW-1:0];
									state_q <= (count_q == '0) ? S_INS_PUT : S_INS_RD;
								end
							end
							slte_pkg::FN_DEL_POS: begin
								if (pos_ext >= count_ext) begin
									status_q <= slte_pkg::ST_BADPOS;
									state_q  <= S_DONE;
								end else begin
									idx_q   <= pos_ext[IW-1:0];
									state_q <= S_SH_RD;
								end
							end
							default: begin
								if (count_q == '0) begin
									status_q <= slte_pkg::ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									idx_q   <= '0;
									state_q <= S_KEY_RD;
								end
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (rd_gt) begin
						idx_q   <= idx_q - IW'(1);
						state_q <= (idx_q == IW'(1)) ? S_INS_PUT : S_INS_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_SH_RD: begin
					if (next_in_range) begin
						state_q <= S_SH_WR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SH_WR: begin
					idx_q   <= idx_q + IW'(1);
					state_q <= S_SH_RD;
				end
				S_KEY_RD: begin
					state_q <= S_KEY_CMP;
				end
				S_KEY_CMP: begin
					if (rd_eq) begin
						if (search_q) begin
							fpos_q  <= idx_ext[3:0];
							state_q <= S_DONE;
						end else begin
							state_q <= S_SH_RD;
						end
					end else if (next_in_range) begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_KEY_RD;
					end else begin
						status_q <= slte_pkg::ST_NOKEY;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/sorted_list_table_engine.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | func, value, position
// out     | output    | out_valid / out_ready | status, found_position, count
//
// work from one accept to the next while the output register is free:
//   insert moves larger entries up one slot, then places the value; full skips the table
//   delete by position moves the entries above it down one slot; bad position skips the table
//   search / delete by key scan in order, a delete then shifts down; empty skips the table
// reset clears the count only; table words are written before they are ever read
// a finished result sits in the output register, so the next item is taken while it waits
module sorted_list_table_engine #(
	parameter int unsigned DEPTH = slte_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] value,
	input  logic [3:0]  position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  found_position,
	output logic [4:0]  count
);

	localparam int unsigned IW = $clog2(DEPTH);

	logic           idle;
	logic           res_valid;
	logic           res_ack;
	slte_pkg::res_t res;
	logic           mem_we;
	logic [IW-1:0]  mem_waddr;
	logic [31:0]    mem_wdata;
	logic [IW-1:0]  mem_raddr;
	logic [31:0]    mem_rdata;

	logic           out_valid_q;
	slte_pkg::res_t out_q;

	// sequencer: works through the table in read-compare-write steps
	slte_ctrl #(
		.DEPTH(DEPTH),
		.IW   (IW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && in_ready),
		.func     (func),
		.value    (value),
		.position (position),
		.idle     (idle),
		.res_valid(res_valid),
		.res_ack  (res_ack),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// sorted entries
	slte_mem #(
		.DEPTH(DEPTH),
		.IW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_ready = idle;

	// output register loads when empty or being drained
	assign res_ack = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_ack) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign found_position = out_q.found_position;
	assign count          = out_q.count;

	// an accepted item keeps the sequencer busy in the cycle after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	// empty status only with an empty table
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == slte_pkg::ST_EMPTY |-> count == 5'd0)
		else $error("empty status with nonzero count");

	// a position is reported only on a successful search
	a_fpos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_position != 4'd0 |-> status == slte_pkg::ST_OK)
		else $error("found position on a failed request");

	// a result is handed over only when the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_ack |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule

FILE: bench/sorted_list_table_engine_tb.sv
module sorted_list_table_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// predictor: keeps its own ordered copy of the table and the results it owes
	class sorted_table_model;
		int held[$];                        // ascending values, front is position zero
		slte_pkg::res_t pending_results[$]; // oldest owed result at the front
		int errors;

		function new();
			errors = 0;
		endfunction

		// work out the result of one accepted request and update the table
		function void note_request(logic [1:0] fn, int v, logic [3:0] p);
			slte_pkg::res_t r;
			int k;
			r.status = slte_pkg::ST_OK;
			r.found_position = '0;
			case (fn)
				slte_pkg::FN_INSERT: begin
					if (held.size() >= slte_pkg::DEPTH_DEF) begin
						r.status = slte_pkg::ST_FULL;
					end else begin
						k = 0;
						while (k < held.size() && held[k] < v)
							k++;
						held.insert(k, v);
					end
				end
				slte_pkg::FN_DEL_POS: begin
					if (int'(p) >= held.size())
						r.status = slte_pkg::ST_BADPOS;
					else
						held.delete(int'(p));
				end
				default: begin
					// search and delete by key share the scan for the first equal entry
					if (held.size() == 0) begin
						r.status = slte_pkg::ST_EMPTY;
					end else begin
						k = 0;
						while (k < held.size() && held[k] != v)
							k++;
						if (k >= held.size())
							r.status = slte_pkg::ST_NOKEY;
						else if (fn == slte_pkg::FN_SEARCH)
							r.found_position = k[3:0];
						else
							held.delete(k);
					end
				end
			endcase
			r.count = 5'(held.size());
			pending_results.push_back(r);
		endfunction

		function int pick_held();
			return held[$urandom_range(0, held.size() - 1)];
		endfunction

		task report_mismatch(string what);
			$display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		// compare one accepted result with the oldest one owed
		task check_result(logic [2:0] st, logic [3:0] fp, logic [4:0] cnt);
			slte_pkg::res_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing owed: status %0d count %0d",
					st, cnt));
			end else begin
				want = pending_results.pop_front();
				if (st !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", st, want.status));
				if (fp !== want.found_position)
					report_mismatch($sformatf("found_position %0d, want %0d",
						fp, want.found_position));
				if (cnt !== want.count)
					report_mismatch($sformatf("count %0d, want %0d", cnt, want.count));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [31:0] value;
	logic [3:0]  position;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [3:0]  found_position;
	logic [4:0]  count;

	sorted_table_model tbl_model;

	// random idling on either side can be switched off for a quiet stretch
	bit tx_idle_on;
	bit rx_idle_on;
	// long receiver hold-off, counted down by the receiver itself
	int stall_cycles;

	sorted_list_table_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.value          (value),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found_position (found_position),
		.count          (count)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// offer one item from the falling edge, hold it until the block takes it
	task automatic send_item(logic [1:0] fn, int v, logic [3:0] p);
		@(negedge clk);
		// random gap before the item, valid low meanwhile
		while (tx_idle_on && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		value <= v;
		position <= p;
		do
			@(posedge clk);
		while (!in_ready);
		tbl_model.note_request(fn, v, p);
	endtask

	// sender goes quiet until every owed result has come back
	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tbl_model.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// values: mostly a narrow band so keys collide, plus held keys, extremes and noise
	function automatic int pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return int'($urandom_range(0, 12)) - 6;
		if (r < 65 && tbl_model.held.size() > 0)
			return tbl_model.pick_held();
		if (r < 80) begin
			case ($urandom_range(0, 5))
				0: return 32'h8000_0000;
				1: return 32'h8000_0001;
				2: return 32'h7fff_fffe;
				3: return 32'h7fff_ffff;
				4: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	// receiver: decides out_ready at each falling edge
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_cycles > 0) begin
				out_ready <= 1'b0;
				stall_cycles--;
			end else begin
				out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 12);
			end
		end
	end

	// every result taken at a rising edge is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tbl_model.check_result(status, found_position, count);
	end

	// stimulus
	initial begin
		int n;
		int mode;
		int ins_pct;
		int pos;
		tbl_model = new();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		stall_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = slte_pkg::FN_INSERT;
		value = '0;
		position = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table: search and delete by key report empty, any position is invalid
		send_item(slte_pkg::FN_SEARCH, 5, 4'd0);
		send_item(slte_pkg::FN_DEL_KEY, 0, 4'd0);
		send_item(slte_pkg::FN_DEL_POS, 0, 4'd0);
		send_item(slte_pkg::FN_DEL_POS, -1, 4'd15);
		// extremes, both signs and a duplicate go in sorted
		send_item(slte_pkg::FN_INSERT, 32'h7fff_ffff, 4'd15);
		send_item(slte_pkg::FN_INSERT, 32'h8000_0000, 4'd0);
		send_item(slte_pkg::FN_INSERT, 0, 4'd5);
		send_item(slte_pkg::FN_INSERT, -1, 4'd10);
		send_item(slte_pkg::FN_INSERT, 1, 4'd3);
		send_item(slte_pkg::FN_INSERT, 0, 4'd12);
		// search: smallest, first of the duplicates, largest, missing key
		send_item(slte_pkg::FN_SEARCH, 32'h8000_0000, 4'd9);
		send_item(slte_pkg::FN_SEARCH, 0, 4'd0);
		send_item(slte_pkg::FN_SEARCH, 32'h7fff_ffff, 4'd7);
		send_item(slte_pkg::FN_SEARCH, 5, 4'd0);
		// delete by position: at the count, far beyond it, then a valid one
		send_item(slte_pkg::FN_DEL_POS, 0, 4'd6);
		send_item(slte_pkg::FN_DEL_POS, 0, 4'd15);
		send_item(slte_pkg::FN_DEL_POS, 0, 4'd1);
		// delete by key: largest entry, missing key, one of the duplicates
		send_item(slte_pkg::FN_DEL_KEY, 32'h7fff_ffff, 4'd0);
		send_item(slte_pkg::FN_DEL_KEY, 12345, 4'd0);
		send_item(slte_pkg::FN_DEL_KEY, 0, 4'd0);

		// random part in phases: filling (reaches full), mixed, draining (reaches empty)
		for (n = 0; n < 1380; n++) begin
			mode = (n / 60) % 3;
			ins_pct = (mode == 0) ? 72 : (mode == 1) ? 40 : 15;

			// receiver holds off for a long time while the sender keeps offering
			if (n == 300)
				stall_cycles = 250;
			// quiet stretch with no idling on either side
			if (n == 500) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			if (n == 720) begin
				tx_idle_on = 1'b1;
				rx_idle_on = 1'b1;
			end
			if (n == 900)
				pause_until_drained();

			if ($urandom_range(0, 99) < ins_pct) begin
				send_item(slte_pkg::FN_INSERT, pick_value(), 4'($urandom_range(0, 15)));
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						// mostly a position that holds an entry, sometimes any position
						if (tbl_model.held.size() > 0 && $urandom_range(0, 99) < 85)
							pos = $urandom_range(0, tbl_model.held.size() - 1);
						else
							pos = $urandom_range(0, 15);
						send_item(slte_pkg::FN_DEL_POS, pick_value(), 4'(pos));
					end
					1: send_item(slte_pkg::FN_SEARCH, pick_value(),
						4'($urandom_range(0, 15)));
					default: send_item(slte_pkg::FN_DEL_KEY, pick_value(),
						4'($urandom_range(0, 15)));
				endcase
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (tbl_model.pending_results.size() != 0)
			@(posedge clk);
		// room for a stray extra result to show up
		repeat (80) @(posedge clk);

		if (tbl_model.errors == 0)
			$display("sorted_list_table_engine_tb passed");
		else
			$display("sorted_list_table_engine_tb failed");
		$finish;
	end

	// watchdog
	initial begin
		#4ms;
		$display("sorted_list_table_engine_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/slte_pkg.sv
rtl/slte_mem.sv
rtl/slte_ctrl.sv
rtl/sorted_list_table_engine.sv
bench/sorted_list_table_engine_tb.sv
